/* src/lswq_pkg.sv */
// lswq_pkg: shared widths, codes and the seven-segment digit patterns
// for the lcd segment weight qualifier; no dependencies
package lswq_pkg;

    localparam int PIN_W    = 8;
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 7;
    localparam int WEIGHT_W = 14;
    localparam int COUNT_W  = 8;
    localparam int NUM_DIGITS = 4;
    localparam int NUM_PATTERNS = 10;

    // decoded code for a pattern that matches no digit
    localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd11;

    // reset value of the stability threshold register
    localparam logic [COUNT_W-1:0] THRESH_RESET = 8'd3;

    // segment patterns .GFEDCBA for digits 0 to 9
    localparam logic [SEG_W-1:0] DIGIT_PATTERN [NUM_PATTERNS] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // the four decoded digits of one frame
    typedef struct packed {
        logic [DIGIT_W-1:0] thousands;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } digits_t;

    // result of the weight qualifier for one frame
    typedef struct packed {
        logic                weight_valid;
        logic [WEIGHT_W-1:0] weight_value;
    } qual_result_t;

endpackage

/* src/lswq_digit_decode.sv */
// lswq_digit_decode: maps the two pins of one digit over four commons to a digit code
// depends on lswq_pkg
module lswq_digit_decode (
    input  logic [1:0]                   com0_pair,
    input  logic [1:0]                   com1_pair,
    input  logic [1:0]                   com2_pair,
    input  logic                         com3_second,
    output logic [lswq_pkg::DIGIT_W-1:0] digit
);

    logic [lswq_pkg::SEG_W-1:0] segs;

    // gather segments: bit 0 is the first pin, bit 1 the second pin of a pair
    // common 3 drives only segment d, on its second pin
    assign segs = {com1_pair[1],    // g
                   com0_pair[1],    // f
                   com2_pair[1],    // e
                   com3_second,     // d
                   com2_pair[0],    // c
                   com1_pair[0],    // b
                   com0_pair[0]};   // a

    // match against the digit patterns, lowest digit wins, blank if none
    always_comb
    begin
        digit = lswq_pkg::BLANK_CODE;
        for (int d = lswq_pkg::NUM_PATTERNS - 1; d >= 0; d--)
        begin
            if (segs == lswq_pkg::DIGIT_PATTERN[d])
            begin
                digit = lswq_pkg::DIGIT_W'(d);
            end
        end
    end

endmodule

/* src/lswq_qualify.sv */
// lswq_qualify: assembles the weight from the digits and tracks repeats to flag it stable
// depends on lswq_pkg
module lswq_qualify (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [lswq_pkg::COUNT_W-1:0] threshold,
    input  lswq_pkg::digits_t            digits,
    output lswq_pkg::qual_result_t       result
);

    logic [lswq_pkg::WEIGHT_W-1:0] prev_weight_reg;
    logic [lswq_pkg::WEIGHT_W-1:0] prev_weight_next;
    logic [lswq_pkg::COUNT_W-1:0]  repeat_count_reg;
    logic [lswq_pkg::COUNT_W-1:0]  repeat_count_next;
    logic [lswq_pkg::COUNT_W-1:0]  count_inc;
    logic [lswq_pkg::WEIGHT_W-1:0] thou_part;
    logic [lswq_pkg::WEIGHT_W-1:0] hund_part;
    logic [lswq_pkg::WEIGHT_W-1:0] weight;
    logic                          tens_shown;

    // digit weights, blank leading digits add nothing
    assign thou_part = (digits.thousands == lswq_pkg::BLANK_CODE) ? '0 :
                       lswq_pkg::WEIGHT_W'(digits.thousands) * lswq_pkg::WEIGHT_W'(1000);
    assign hund_part = (digits.hundreds == lswq_pkg::BLANK_CODE) ? '0 :
                       lswq_pkg::WEIGHT_W'(digits.hundreds) * lswq_pkg::WEIGHT_W'(100);
    assign weight    = thou_part + hund_part
                     + lswq_pkg::WEIGHT_W'(digits.tens) * lswq_pkg::WEIGHT_W'(10)
                     + lswq_pkg::WEIGHT_W'(digits.ones);

    assign tens_shown = (digits.tens != lswq_pkg::BLANK_CODE);
    assign count_inc  = repeat_count_reg + 1'b1;

    // repeat tracking and qualification
    always_comb
    begin
        prev_weight_next    = prev_weight_reg;
        repeat_count_next   = repeat_count_reg;
        result.weight_valid = 1'b0;
        result.weight_value = '0;
        if (tens_shown)
        begin
            result.weight_value = weight;
            prev_weight_next    = weight;
            if (weight == prev_weight_reg)
            begin
                if (count_inc > threshold)
                begin
                    repeat_count_next   = '0;
                    result.weight_valid = 1'b1;
                end
                else
                begin
                    repeat_count_next = count_inc;
                end
            end
            else
            begin
                repeat_count_next = '0;
            end
        end
        else
        begin
            prev_weight_next = '0;
        end
    end

    // state advances once per item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_weight_reg  <= '0;
            repeat_count_reg <= '0;
        end
        else if (advance)
        begin
            prev_weight_reg  <= prev_weight_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

endmodule

/* src/lcd_segment_weight_qualifier.sv */
// lcd_segment_weight_qualifier: top level with input register, digit decoders,
// weight qualifier and result register; depends on lswq_pkg, lswq_digit_decode, lswq_qualify
//
// Takes one captured multiplexed lcd frame per item (four pin snapshots, one per common)
// and returns one result per item: the four decoded digits, the assembled weight and a
// flag set on the frame where the same weight has repeated more than stable_threshold
// times. An item sits in an input register, is decoded and qualified in one pass of
// shallow logic, and lands in a result register unless a stalled result still holds it
// there; one item is taken every cycle while the result side keeps up.
// The repeat counter and previous weight update when an item moves into the result
// register. Write stable_threshold only while the block holds no item.
module lcd_segment_weight_qualifier (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic [lswq_pkg::COUNT_W-1:0] cfg_wdata,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lswq_pkg::PIN_W-1:0]   com0_pins,
    input  logic [lswq_pkg::PIN_W-1:0]   com1_pins,
    input  logic [lswq_pkg::PIN_W-1:0]   com2_pins,
    input  logic [lswq_pkg::PIN_W-1:0]   com3_pins,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         weight_valid,
    output logic [lswq_pkg::WEIGHT_W-1:0] weight_value,
    output logic [lswq_pkg::DIGIT_W-1:0] digit_ones,
    output logic [lswq_pkg::DIGIT_W-1:0] digit_tens,
    output logic [lswq_pkg::DIGIT_W-1:0] digit_hundreds,
    output logic [lswq_pkg::DIGIT_W-1:0] digit_thousands
);

    logic [lswq_pkg::COUNT_W-1:0] threshold_reg;
    logic                         in_valid_reg;
    logic [lswq_pkg::PIN_W-1:0]   com0_reg;
    logic [lswq_pkg::PIN_W-1:0]   com1_reg;
    logic [lswq_pkg::PIN_W-1:0]   com2_reg;
    logic [lswq_pkg::PIN_W-1:0]   com3_reg;
    logic                         out_valid_reg;
    lswq_pkg::digits_t            digits_reg;
    lswq_pkg::qual_result_t       result_reg;

    lswq_pkg::digits_t            digits;
    lswq_pkg::qual_result_t       result;
    logic [lswq_pkg::DIGIT_W-1:0] digit_vec [lswq_pkg::NUM_DIGITS];
    logic                         out_free;
    logic                         advance;
    logic                         in_accept;

    // handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= lswq_pkg::THRESH_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            com0_reg <= com0_pins;
            com1_reg <= com1_pins;
            com2_reg <= com2_pins;
            com3_reg <= com3_pins;
        end
    end

    // one decoder per digit, digit k on pin bits 2k and 2k+1
    for (genvar k = 0; k < lswq_pkg::NUM_DIGITS; k++)
    begin : g_digit
        lswq_digit_decode u_decode (
            .com0_pair   (com0_reg[2*k +: 2]),
            .com1_pair   (com1_reg[2*k +: 2]),
            .com2_pair   (com2_reg[2*k +: 2]),
            .com3_second (com3_reg[2*k+1]),
            .digit       (digit_vec[k])
        );
    end

    assign digits.ones      = digit_vec[0];
    assign digits.tens      = digit_vec[1];
    assign digits.hundreds  = digit_vec[2];
    assign digits.thousands = digit_vec[3];

    // weight assembly and stability tracking
    lswq_qualify u_qualify (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .threshold (threshold_reg),
        .digits    (digits),
        .result    (result)
    );

    // result payload register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            digits_reg <= digits;
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign weight_valid    = result_reg.weight_valid;
    assign weight_value    = result_reg.weight_value;
    assign digit_ones      = digits_reg.ones;
    assign digit_tens      = digits_reg.tens;
    assign digit_hundreds  = digits_reg.hundreds;
    assign digit_thousands = digits_reg.thousands;

endmodule

/* dv/tb_lcd_segment_weight_qualifier.sv */
// tb_lcd_segment_weight_qualifier: self-checking testbench for the lcd segment weight qualifier
// drives captured lcd frames and checks every result against a local predictor
// depends on lswq_pkg and lcd_segment_weight_qualifier
module tb_lcd_segment_weight_qualifier;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 130;
    localparam int DRAIN_CYCLES = 4;

    // decoded value of a segment pattern that is no digit
    localparam logic [3:0] SEG_BLANK = 4'd11;

    // segments .GFEDCBA lit for digits 0 to 9
    localparam logic [6:0] DIGIT_SEGS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // one frame: index 0 holds the pins sampled during common 0
    typedef logic [3:0][7:0] frame_t;

    typedef struct packed {
        logic                          valid;
        logic [lswq_pkg::WEIGHT_W-1:0] weight;
        logic [3:0]                    ones;
        logic [3:0]                    tens;
        logic [3:0]                    hund;
        logic [3:0]                    thou;
    } reading_t;

    typedef struct {
        frame_t   frame;
        bit       typed;
        reading_t reading;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lswq_pkg::COUNT_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic [lswq_pkg::PIN_W-1:0] com0_pins;
    logic [lswq_pkg::PIN_W-1:0] com1_pins;
    logic [lswq_pkg::PIN_W-1:0] com2_pins;
    logic [lswq_pkg::PIN_W-1:0] com3_pins;
    logic out_valid;
    logic out_stall;
    logic weight_valid;
    logic [lswq_pkg::WEIGHT_W-1:0] weight_value;
    logic [lswq_pkg::DIGIT_W-1:0] digit_ones;
    logic [lswq_pkg::DIGIT_W-1:0] digit_tens;
    logic [lswq_pkg::DIGIT_W-1:0] digit_hundreds;
    logic [lswq_pkg::DIGIT_W-1:0] digit_thousands;

    // predictor state and configuration
    logic [13:0] model_weight;
    logic [7:0]  repeat_cnt;
    logic [7:0]  threshold;

    reading_t  pending_readings [$];
    stim_row_t sent_rows [$];
    stim_row_t directed_rows [$];
    int        mismatch_count;
    int        cycle_count;
    int        stall_left;
    bit        hush;

    lcd_segment_weight_qualifier uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .com0_pins       (com0_pins),
        .com1_pins       (com1_pins),
        .com2_pins       (com2_pins),
        .com3_pins       (com3_pins),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .weight_valid    (weight_valid),
        .weight_value    (weight_value),
        .digit_ones      (digit_ones),
        .digit_tens      (digit_tens),
        .digit_hundreds  (digit_hundreds),
        .digit_thousands (digit_thousands)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // random segment pattern that matches no digit
    function automatic logic [6:0] blank_pattern();
        logic [6:0] p;
        bit hit;
        do
        begin
            p = 7'($urandom);
            hit = 1'b0;
            for (int d = 0; d < 10; d++)
                if (p == DIGIT_SEGS[d])
                    hit = 1'b1;
        end
        while (hit);
        return p;
    endfunction

    // pins for four digit codes, blanks get a random non-digit pattern
    function automatic frame_t build_frame(logic [3:0] thou, logic [3:0] hund,
                                           logic [3:0] tens, logic [3:0] ones);
        logic [3:0] codes [4];
        logic [6:0] s;
        frame_t f;
        codes = '{ones, tens, hund, thou};
        f = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = (codes[k] <= 4'd9) ? DIGIT_SEGS[codes[k]] : blank_pattern();
            f[0][2*k]   = s[0];
            f[0][2*k+1] = s[5];
            f[1][2*k]   = s[1];
            f[1][2*k+1] = s[6];
            f[2][2*k]   = s[2];
            f[2][2*k+1] = s[4];
            f[3][2*k+1] = s[3];
            // unused pin of common 3
            f[3][2*k]   = 1'($urandom);
        end
        return f;
    endfunction

    // digit shown at position k of a frame
    function automatic logic [3:0] read_digit(frame_t f, int k);
        logic [6:0] s;
        s = {f[1][2*k+1], f[0][2*k+1], f[2][2*k+1], f[3][2*k+1],
             f[2][2*k], f[1][2*k], f[0][2*k]};
        for (int d = 0; d < 10; d++)
            if (s == DIGIT_SEGS[d])
                return 4'(d);
        return SEG_BLANK;
    endfunction

    // decode one frame and update the stability tracking
    function automatic reading_t qualify_frame(frame_t f);
        reading_t r;
        int w;
        r = '0;
        r.ones = read_digit(f, 0);
        r.tens = read_digit(f, 1);
        r.hund = read_digit(f, 2);
        r.thou = read_digit(f, 3);
        if (r.tens != SEG_BLANK)
        begin
            w = r.tens * 10 + r.ones;
            if (r.thou != SEG_BLANK)
                w += r.thou * 1000;
            if (r.hund != SEG_BLANK)
                w += r.hund * 100;
            r.weight = 14'(w);
            if (r.weight == model_weight)
            begin
                repeat_cnt = repeat_cnt + 8'd1;
                if (repeat_cnt > threshold)
                begin
                    repeat_cnt = '0;
                    r.valid = 1'b1;
                end
            end
            else
                repeat_cnt = '0;
            model_weight = r.weight;
        end
        else
            model_weight = '0;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checking and prediction of accepted items
    always @(posedge clk)
    begin
        reading_t want;
        stim_row_t row;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_readings.size() == 0)
                begin
                    $display("%0t: result with no item pending, weight %0d", $time,
                             weight_value);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    check_field("weight_valid", want.valid, weight_valid);
                    check_field("weight_value", want.weight, weight_value);
                    check_field("digit_ones", want.ones, digit_ones);
                    check_field("digit_tens", want.tens, digit_tens);
                    check_field("digit_hundreds", want.hund, digit_hundreds);
                    check_field("digit_thousands", want.thou, digit_thousands);
                end
            end
            if (in_valid && !in_stall)
            begin
                want = qualify_frame({com3_pins, com2_pins, com1_pins, com0_pins});
                if (sent_rows.size() != 0)
                begin
                    row = sent_rows.pop_front();
                    if (row.typed)
                        want = row.reading;
                end
                pending_readings.push_back(want);
            end
        end
    end

    // result side stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!hush && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one item, return at the edge where it is taken
    task automatic send_frame(frame_t f, bit typed = 1'b0, reading_t r = '0);
        stim_row_t row;
        if (!hush && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        row.frame = f;
        row.typed = typed;
        row.reading = r;
        sent_rows.push_back(row);
        in_valid <= 1'b1;
        com0_pins <= f[0];
        com1_pins <= f[1];
        com2_pins <= f[2];
        com3_pins <= f[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering items and wait until all results are in
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0 || sent_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        threshold = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] pick_digit();
        return ($urandom_range(0, 7) == 0) ? SEG_BLANK : 4'($urandom_range(0, 9));
    endfunction

    // runs of repeated weights with random digits, plus noise frames
    task automatic run_phase(int n_items, bit allow_idle);
        int sent;
        int run_len;
        bit first;
        logic [3:0] th, hu, te, on;
        sent = 0;
        first = 1'b1;
        // without idling, let any running stall burst finish first
        if (!allow_idle)
        begin
            hush = 1'b1;
            while (stall_left != 0 || out_stall)
                @(posedge clk);
        end
        while (sent < n_items)
        begin
            hush = !allow_idle || ($urandom_range(0, 3) == 0);
            if (!first && $urandom_range(0, 9) == 0)
            begin
                run_len = $urandom_range(1, 4);
                repeat (run_len) send_frame(frame_t'($urandom));
            end
            else
            begin
                th = pick_digit();
                hu = pick_digit();
                on = pick_digit();
                te = ($urandom_range(0, 9) == 0) ? SEG_BLANK : 4'($urandom_range(0, 9));
                // first run reaches the threshold, including the counter wrap
                if (first)
                    run_len = threshold + 2;
                else
                    run_len = $urandom_range(1, (threshold > 8 ? 8 : threshold) + 3);
                for (int i = 0; i < run_len; i++)
                begin
                    if (!first && $urandom_range(0, 24) == 0)
                        send_frame(build_frame(th, hu, SEG_BLANK, on));
                    else
                        send_frame(build_frame(th, hu, te, on));
                end
            end
            first = 1'b0;
            sent += run_len;
        end
    endtask

    // stimulus
    initial
    begin
        stim_row_t row;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        com0_pins = '0;
        com1_pins = '0;
        com2_pins = '0;
        com3_pins = '0;
        out_stall = 1'b0;
        stall_left = 0;
        hush = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        model_weight = '0;
        repeat_cnt = '0;
        threshold = lswq_pkg::THRESH_RESET;

        // directed table: typed results only where obvious
        row.typed = 1'b1;
        // no segments lit: all blank
        row.frame = '0;
        row.reading = '{1'b0, 14'd0, SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK};
        directed_rows.push_back(row);
        // every segment lit: all eights
        row.frame = '1;
        row.reading = '{1'b0, 14'd8888, 4'd8, 4'd8, 4'd8, 4'd8};
        directed_rows.push_back(row);
        // largest weight, blank ones digit adds eleven
        row.frame = build_frame(4'd9, 4'd9, 4'd9, SEG_BLANK);
        row.reading = '{1'b0, 14'd10001, SEG_BLANK, 4'd9, 4'd9, 4'd9};
        directed_rows.push_back(row);
        row.typed = 1'b0;
        // same weight until it qualifies
        repeat (4)
        begin
            row.frame = build_frame(4'd9, 4'd9, 4'd9, SEG_BLANK);
            directed_rows.push_back(row);
        end
        row.frame = build_frame(SEG_BLANK, SEG_BLANK, 4'd0, 4'd0);
        directed_rows.push_back(row);
        // tens blank clears the previous weight but keeps the count
        row.frame = build_frame(SEG_BLANK, SEG_BLANK, SEG_BLANK, 4'd5);
        directed_rows.push_back(row);
        row.frame = build_frame(SEG_BLANK, SEG_BLANK, 4'd0, 4'd0);
        directed_rows.push_back(row);
        row.frame = build_frame(4'd1, 4'd2, 4'd3, 4'd4);
        directed_rows.push_back(row);
        row.frame = build_frame(4'd5, 4'd6, 4'd7, 4'd8);
        directed_rows.push_back(row);
        row.frame = build_frame(4'd9, 4'd0, 4'd1, 4'd2);
        directed_rows.push_back(row);
        row.frame = build_frame(SEG_BLANK, 4'd7, SEG_BLANK, 4'd3);
        directed_rows.push_back(row);
        row.frame = build_frame(4'd0, SEG_BLANK, 4'd6, SEG_BLANK);
        directed_rows.push_back(row);
        // only the unused common 3 pins high
        row.frame = {8'h55, 8'h00, 8'h00, 8'h00};
        directed_rows.push_back(row);
        // all lit except the unused pins
        row.frame = {8'hAA, 8'hFF, 8'hFF, 8'hFF};
        directed_rows.push_back(row);
        repeat (5)
        begin
            row.frame = build_frame(4'd1, 4'd2, 4'd3, 4'd4);
            directed_rows.push_back(row);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_frame(directed_rows[i].frame, directed_rows[i].typed,
                       directed_rows[i].reading);

        // random phases across thresholds, extremes included
        set_threshold(8'd0);
        run_phase(PHASE_ITEMS, 1'b1);
        set_threshold(8'd1);
        run_phase(PHASE_ITEMS, 1'b1);
        set_threshold(8'd255);
        run_phase(PHASE_ITEMS, 1'b1);
        set_threshold(8'd254);
        run_phase(PHASE_ITEMS, 1'b1);
        set_threshold(8'($urandom_range(2, 12)));
        run_phase(PHASE_ITEMS, 1'b1);
        set_threshold(8'($urandom_range(0, 254)));
        run_phase(PHASE_ITEMS, 1'b1);
        // last part runs without idling
        set_threshold(8'd3);
        run_phase(PHASE_ITEMS, 1'b0);

        drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
